// File: src/dh_chain_forward_kinematics_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DH chain forward kinematics block
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DH_CHAIN_FORWARD_KINEMATICS_ASSERT_SVH
`define DH_CHAIN_FORWARD_KINEMATICS_ASSERT_SVH

// Same-cycle implication.
`define DHFK_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("dhfk assertion failed");

// Next-cycle implication.
`define DHFK_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("dhfk assertion failed");

`endif

// File: src/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// Types and constants of the DH chain forward kinematics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhfk_pkg;

  // Joint kinds carried in tuser; the unused code acts as a fixed joint.
  localparam logic [1:0] KIND_REVOLUTE  = 2'd0;
  localparam logic [1:0] KIND_PRISMATIC = 2'd1;

  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam int unsigned SERIES_TERMS = 12;
  localparam int unsigned IN_W  = 128;
  localparam int unsigned OUT_W = 384;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIG_MUL,
    S_TRIG_ADD,
    S_DIV,
    S_SERIES,
    S_TRIG_END,
    S_JNT_MUL,
    S_JNT_ADD,
    S_MAT_MUL,
    S_MAT_ADD,
    S_MAT_WB,
    S_COMMIT
  } state_e;

  // Wide multiply being built from 32x32 partial products.
  typedef enum logic [1:0] {
    OP_X,
    OP_X2,
    OP_TERM
  } trig_op_e;

endpackage

// File: src/dh_chain_forward_kinematics.sv
// ----------------------------------------------------------------------------
// dh_chain_forward_kinematics
// Serial-chain forward kinematics, standard Denavit-Hartenberg, one joint
// per beat, on a single shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one joint. tdata holds, from bit 0 up,
// link_offset, joint_angle_offset, link_length, link_twist and joint_value;
// tuser holds joint_kind and tlast marks the last joint of a chain. The
// joint transform right-multiplies the kept pose. After a beat with tlast
// set, one output beat carries the nine rotation entries and the position,
// and the kept pose goes back to identity.
// Pacing: once a joint is accepted, s_axis_tready_o stays low and the
// block takes no beat until that joint is done.
// Nearly all of the work is the four sine and cosine evaluations: each runs a
// twelve-term series in which every term costs one 64x64 product built
// from four passes through the 33x33 multiplier and a 64-bit division by a
// small constant retired four quotient bits per cycle. The joint transform
// and the 3x4 matrix product then follow on the same multiplier. The
// result sits in an output register, so the next joint is accepted while
// it waits; a stalled receiver only holds the block back when a second
// pose is ready before the first was taken.
// Reset clears the kept pose to identity and drops the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dh_chain_forward_kinematics (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // link_offset[31:0], joint_angle_offset[47:32], link_length[79:48],
  // link_twist[95:80], joint_value[127:96]
  input  logic [127:0] s_axis_tdata_i,
  // joint_kind[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // pos_x, pos_y, pos_z, 32 bits each from bit 0 up
  output logic [383:0] m_axis_tdata_o
);

  dhfk_pkg::state_e   state_q, state_d;
  dhfk_pkg::trig_op_e op_q;

  // Latched joint.
  logic [15:0]        theta_q, alpha_q;
  logic signed [31:0] a_q, d_q;
  logic               last_q;

  // Kept pose and the pose under construction.
  logic signed [31:0] rot_q [9];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] nrot_q [9];
  logic signed [31:0] npos_q [3];

  // Joint transform.
  logic signed [31:0] rj_q [9];
  logic signed [31:0] pj_q [3];

  // Series evaluation.
  logic [1:0]   trig_idx_q;
  logic [1:0]   pp_q;
  logic [3:0]   term_i_q;
  logic [3:0]   dcnt_q;
  logic [127:0] uacc_q;
  logic [63:0]  x_q, x2_q, term_q, sum_q, quo_q;
  logic [10:0]  rem_q;
  logic [30:0]  oct_q [4];

  // Joint and matrix counters.
  logic [2:0]   jstep_q;
  logic [1:0]   mr_q, mc_q, mk_q;
  logic signed [63:0] sacc_q;
  logic [63:0]  prod_q;

  logic         out_valid_q;
  logic [383:0] out_data_q;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- helpers ----------------
  function automatic logic signed [33:0] round_q30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd536870912;
    return t[63:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -36'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // ---------------- series operand selection ----------------
  logic [15:0] angle;
  logic [13:0] r_raw, rr;
  logic        fold, want_sin;
  logic [4:0]  n_val;
  logic [9:0]  div_val;

  assign angle    = trig_idx_q[1] ? alpha_q : theta_q;
  assign r_raw    = angle[13:0];
  assign fold     = r_raw > 14'd8192;
  assign rr       = fold ? (14'd0 - r_raw) : r_raw;
  assign want_sin = (~trig_idx_q[0]) ^ fold;
  assign n_val    = (want_sin ? 5'd2 : 5'd1) + {term_i_q, 1'b0};
  assign div_val  = 10'({5'b0, n_val} * ({5'b0, n_val} + 10'd1));

  // Quadrant fold of the octant values into signed sine and cosine.
  logic [1:0]         quad_t, quad_a;
  logic signed [31:0] st, ct, sa, ca;

  always_comb begin
    logic signed [31:0] s0t, c0t, s0a, c0a;
    s0t = {1'b0, oct_q[0]};
    c0t = {1'b0, oct_q[1]};
    s0a = {1'b0, oct_q[2]};
    c0a = {1'b0, oct_q[3]};
    quad_t = theta_q[15:14];
    quad_a = alpha_q[15:14];
    unique case (quad_t)
      2'd0:    begin st = s0t;  ct = c0t;  end
      2'd1:    begin st = c0t;  ct = -s0t; end
      2'd2:    begin st = -s0t; ct = -c0t; end
      default: begin st = -c0t; ct = s0t;  end
    endcase
    unique case (quad_a)
      2'd0:    begin sa = s0a;  ca = c0a;  end
      2'd1:    begin sa = c0a;  ca = -s0a; end
      2'd2:    begin sa = -s0a; ca = -c0a; end
      default: begin sa = -c0a; ca = s0a;  end
    endcase
  end

  // ---------------- shared multiplier ----------------
  logic [63:0]        wide_a, wide_b;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [3:0]         ridx, jidx;

  assign ridx = 4'(mr_q) * 4'd3 + 4'(mk_q);
  assign jidx = 4'(mk_q) * 4'd3 + 4'(mc_q);

  always_comb begin
    logic [31:0] pa, pb;
    unique case (op_q)
      dhfk_pkg::OP_X: begin
        wide_a = 64'(rr) << 49;
        wide_b = dhfk_pkg::PI_Q62;
      end
      dhfk_pkg::OP_X2: begin
        wide_a = x_q;
        wide_b = x_q;
      end
      default: begin
        wide_a = term_q;
        wide_b = x2_q;
      end
    endcase
    pa = pp_q[1] ? wide_a[63:32] : wide_a[31:0];
    pb = pp_q[0] ? wide_b[63:32] : wide_b[31:0];
    mul_a = {1'b0, pa};
    mul_b = {1'b0, pb};
    if (state_q == dhfk_pkg::S_JNT_MUL) begin
      unique case (jstep_q)
        3'd0:    begin mul_a = 33'(st);  mul_b = 33'(ca); end
        3'd1:    begin mul_a = 33'(st);  mul_b = 33'(sa); end
        3'd2:    begin mul_a = 33'(ct);  mul_b = 33'(ca); end
        3'd3:    begin mul_a = 33'(ct);  mul_b = 33'(sa); end
        3'd4:    begin mul_a = 33'(a_q); mul_b = 33'(ct); end
        default: begin mul_a = 33'(a_q); mul_b = 33'(st); end
      endcase
    end else if (state_q == dhfk_pkg::S_MAT_MUL) begin
      mul_a = 33'(rot_q[ridx]);
      mul_b = (mc_q == 2'd3) ? 33'(pj_q[mk_q]) : 33'(rj_q[jidx]);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Partial product accumulation for the wide multiply.
  logic [127:0] uacc_n;
  logic [6:0]   pp_shift;
  assign pp_shift = 7'({1'b0, pp_q[1]} + {1'b0, pp_q[0]}) << 5;
  assign uacc_n   = uacc_q + ({64'b0, prod_q} << pp_shift);

  // Four quotient bits per cycle.
  logic [63:0] quo_n;
  logic [10:0] rem_n;
  always_comb begin
    quo_n = quo_q;
    rem_n = rem_q;
    for (int i = 0; i < 4; i++) begin
      rem_n = {rem_n[9:0], quo_n[63]};
      quo_n = {quo_n[62:0], 1'b0};
      if (rem_n >= {1'b0, div_val}) begin
        rem_n = rem_n - {1'b0, div_val};
        quo_n[0] = 1'b1;
      end
    end
  end

  // Rounding of the product register and the matrix accumulator.
  logic signed [33:0] jrnd, mrnd;
  logic signed [35:0] psum;
  logic signed [31:0] rclamp;
  assign jrnd = round_q30(prod_q);
  assign mrnd = round_q30(sacc_q);
  assign psum = 36'(mrnd) + 36'(pos_q[mr_q]);
  assign rclamp = (mrnd > 34'(dhfk_pkg::ONE_Q30)) ? dhfk_pkg::ONE_Q30 :
                  (mrnd < -34'(dhfk_pkg::ONE_Q30)) ? -dhfk_pkg::ONE_Q30 :
                  mrnd[31:0];

  logic commit_ok;
  assign commit_ok = !last_q || !out_valid_q || m_axis_tready_i;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhfk_pkg::S_IDLE:     if (s_acc) state_d = dhfk_pkg::S_TRIG_MUL;
      dhfk_pkg::S_TRIG_MUL: state_d = dhfk_pkg::S_TRIG_ADD;
      dhfk_pkg::S_TRIG_ADD: begin
        if (pp_q == 2'd3 && op_q == dhfk_pkg::OP_TERM) state_d = dhfk_pkg::S_DIV;
        else state_d = dhfk_pkg::S_TRIG_MUL;
      end
      dhfk_pkg::S_DIV:      if (dcnt_q == 4'd15) state_d = dhfk_pkg::S_SERIES;
      dhfk_pkg::S_SERIES: begin
        if (term_i_q == 4'(dhfk_pkg::SERIES_TERMS - 1)) state_d = dhfk_pkg::S_TRIG_END;
        else state_d = dhfk_pkg::S_TRIG_MUL;
      end
      dhfk_pkg::S_TRIG_END: begin
        if (trig_idx_q == 2'd3) state_d = dhfk_pkg::S_JNT_MUL;
        else state_d = dhfk_pkg::S_TRIG_MUL;
      end
      dhfk_pkg::S_JNT_MUL:  state_d = dhfk_pkg::S_JNT_ADD;
      dhfk_pkg::S_JNT_ADD: begin
        if (jstep_q == 3'd5) state_d = dhfk_pkg::S_MAT_MUL;
        else state_d = dhfk_pkg::S_JNT_MUL;
      end
      dhfk_pkg::S_MAT_MUL:  state_d = dhfk_pkg::S_MAT_ADD;
      dhfk_pkg::S_MAT_ADD: begin
        if (mk_q == 2'd2) state_d = dhfk_pkg::S_MAT_WB;
        else state_d = dhfk_pkg::S_MAT_MUL;
      end
      dhfk_pkg::S_MAT_WB: begin
        if (mr_q == 2'd2 && mc_q == 2'd3) state_d = dhfk_pkg::S_COMMIT;
        else state_d = dhfk_pkg::S_MAT_MUL;
      end
      dhfk_pkg::S_COMMIT:   if (commit_ok) state_d = dhfk_pkg::S_IDLE;
      default:              state_d = dhfk_pkg::S_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    s_axis_tready_o = (state_q == dhfk_pkg::S_IDLE);
    m_axis_tvalid_o = out_valid_q;
    m_axis_tdata_o  = out_data_q;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dhfk_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        rot_q[i] <= (i % 4 == 0) ? dhfk_pkg::ONE_Q30 : 32'sd0;
      end
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= 32'sd0;
      end
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid_o && m_axis_tready_i) out_valid_q <= 1'b0;
      if (state_q == dhfk_pkg::S_COMMIT && commit_ok) begin
        if (last_q) begin
          out_valid_q <= 1'b1;
          for (int i = 0; i < 9; i++) begin
            rot_q[i] <= (i % 4 == 0) ? dhfk_pkg::ONE_Q30 : 32'sd0;
          end
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= 32'sd0;
          end
        end else begin
          rot_q <= nrot_q;
          pos_q <= npos_q;
        end
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dhfk_pkg::S_IDLE: begin
        if (s_acc) begin
          logic signed [31:0] d_in, v_in;
          d_in = s_axis_tdata_i[31:0];
          v_in = s_axis_tdata_i[127:96];
          alpha_q <= s_axis_tdata_i[95:80];
          a_q     <= s_axis_tdata_i[79:48];
          last_q  <= s_axis_tlast_i;
          theta_q <= (s_axis_tuser_i == dhfk_pkg::KIND_REVOLUTE) ?
                     s_axis_tdata_i[47:32] + v_in[15:0] : s_axis_tdata_i[47:32];
          d_q     <= (s_axis_tuser_i == dhfk_pkg::KIND_PRISMATIC) ?
                     sat32(36'(d_in) + 36'(v_in)) : d_in;
          trig_idx_q <= 2'd0;
          op_q    <= dhfk_pkg::OP_X;
          pp_q    <= 2'd0;
          uacc_q  <= '0;
        end
      end
      dhfk_pkg::S_TRIG_MUL: prod_q <= mul_p[63:0];
      dhfk_pkg::S_TRIG_ADD: begin
        if (pp_q == 2'd3) begin
          pp_q   <= 2'd0;
          uacc_q <= '0;
          unique case (op_q)
            dhfk_pkg::OP_X: begin
              x_q  <= uacc_n[127:64];
              op_q <= dhfk_pkg::OP_X2;
            end
            dhfk_pkg::OP_X2: begin
              x2_q     <= uacc_n[125:62];
              term_q   <= want_sin ? x_q : 64'h4000_0000_0000_0000;
              sum_q    <= want_sin ? x_q : 64'h4000_0000_0000_0000;
              term_i_q <= 4'd0;
              op_q     <= dhfk_pkg::OP_TERM;
            end
            default: begin
              quo_q  <= uacc_n[125:62];
              rem_q  <= '0;
              dcnt_q <= 4'd0;
            end
          endcase
        end else begin
          pp_q   <= pp_q + 2'd1;
          uacc_q <= uacc_n;
        end
      end
      dhfk_pkg::S_DIV: begin
        quo_q  <= quo_n;
        rem_q  <= rem_n;
        dcnt_q <= dcnt_q + 4'd1;
      end
      dhfk_pkg::S_SERIES: begin
        term_q   <= quo_q;
        sum_q    <= term_i_q[0] ? sum_q + quo_q : sum_q - quo_q;
        term_i_q <= term_i_q + 4'd1;
      end
      dhfk_pkg::S_TRIG_END: begin
        logic [63:0] rs;
        rs = sum_q + 64'h8000_0000;
        oct_q[trig_idx_q] <= rs[62:32];
        trig_idx_q <= trig_idx_q + 2'd1;
        op_q       <= dhfk_pkg::OP_X;
        jstep_q    <= 3'd0;
      end
      dhfk_pkg::S_JNT_MUL: prod_q <= mul_p[63:0];
      dhfk_pkg::S_JNT_ADD: begin
        unique case (jstep_q)
          3'd0: begin
            rj_q[1] <= -jrnd[31:0];
            rj_q[0] <= ct;
            rj_q[3] <= st;
            rj_q[6] <= 32'sd0;
            rj_q[7] <= sa;
            rj_q[8] <= ca;
            pj_q[2] <= d_q;
          end
          3'd1:    rj_q[2] <= jrnd[31:0];
          3'd2:    rj_q[4] <= jrnd[31:0];
          3'd3:    rj_q[5] <= -jrnd[31:0];
          3'd4:    pj_q[0] <= sat32(36'(jrnd));
          default: pj_q[1] <= sat32(36'(jrnd));
        endcase
        jstep_q <= jstep_q + 3'd1;
        mr_q    <= 2'd0;
        mc_q    <= 2'd0;
        mk_q    <= 2'd0;
        sacc_q  <= '0;
      end
      dhfk_pkg::S_MAT_MUL: prod_q <= mul_p[63:0];
      dhfk_pkg::S_MAT_ADD: begin
        sacc_q <= sacc_q + $signed(prod_q);
        mk_q   <= mk_q + 2'd1;
      end
      dhfk_pkg::S_MAT_WB: begin
        if (mc_q == 2'd3) begin
          npos_q[mr_q] <= sat32(psum);
          mc_q <= 2'd0;
          mr_q <= mr_q + 2'd1;
        end else begin
          nrot_q[4'(mr_q) * 4'd3 + 4'(mc_q)] <= rclamp;
          mc_q <= mc_q + 2'd1;
        end
        mk_q   <= 2'd0;
        sacc_q <= '0;
      end
      dhfk_pkg::S_COMMIT: begin
        if (commit_ok && last_q) begin
          for (int i = 0; i < 9; i++) begin
            out_data_q[32*i +: 32] <= nrot_q[i];
          end
          for (int i = 0; i < 3; i++) begin
            out_data_q[288 + 32*i +: 32] <= npos_q[i];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/dhfk_checker.sv
// ----------------------------------------------------------------------------
// dhfk_checker
// Port-level assertions for the DH chain forward kinematics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dh_chain_forward_kinematics_assert.svh"

module dhfk_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [127:0] s_axis_tdata_i,
  input logic [1:0]   s_axis_tuser_i,
  input logic         s_axis_tlast_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [383:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A pose that is not taken stays put.
  `DHFK_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                    m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // One joint at a time: the sequencer is busy right after it takes one.
  `DHFK_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_axis_tready_o)

  // A pose never appears on the cycle after a joint is taken.
  `DHFK_ASSERT_NEXT(a_no_instant_pose, s_acc, !$rose(m_axis_tvalid_o))

endmodule

bind dh_chain_forward_kinematics dhfk_checker u_dhfk_checker (.*);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DH chain forward kinematics block. Joints are
// driven as input beats and the kept pose is predicted in the bench. Every
// output beat is compared field by field with the oldest predicted pose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] KIND_FIXED  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam longint     Q30_ONE     = 64'sd1 << 30;
  localparam int         CYCLE_LIMIT = 4_000_000;
  localparam int         DRAIN_WAIT  = 3000;

  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] theta;
    logic [31:0] length;
    logic [15:0] twist;
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
  } joint_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [383:0] m_tdata;

  joint_t       joint_q[$];
  logic [383:0] pose_q[$];
  longint       pose_rot[9];
  longint       pose_pos[3];
  int           errors = 0;
  int           cycles = 0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           rx_hold = 6000;

  dh_chain_forward_kinematics dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Product of two Q62 values taken back to Q62, bits 125 down to 62.
  function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Sine or cosine over one octant, rounded to Q1.30.
  function automatic longint unsigned octant_q30(int unsigned r, bit want_sin);
    logic [127:0]    p;
    longint unsigned x, x2, term, sum, n;
    p = {64'd0, 64'(r) << 49} * {64'd0, dhfk_pkg::PI_Q62};
    x = p[127:64];
    x2 = mul_q62(x, x);
    term = want_sin ? x : (64'd1 << 62);
    sum = term;
    for (int i = 0; i < dhfk_pkg::SERIES_TERMS; i++) begin
      n = (want_sin ? 64'd2 : 64'd1) + 2 * i;
      term = mul_q62(term, x2) / (n * (n + 1));
      if ((i & 1) == 0) sum -= term;
      else sum += term;
    end
    return (sum + (64'd1 << 31)) >> 32;
  endfunction

  task automatic sin_cos(input logic [15:0] k, output longint s, output longint c);
    int unsigned r;
    longint      s0, c0;
    r = k[13:0];
    if (r <= 8192) begin
      s0 = octant_q30(r, 1'b1);
      c0 = octant_q30(r, 1'b0);
    end else begin
      s0 = octant_q30(16384 - r, 1'b0);
      c0 = octant_q30(16384 - r, 1'b1);
    end
    case (k[15:14])
      2'd0: begin s = s0;  c = c0;  end
      2'd1: begin s = c0;  c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  function automatic longint rnd30(longint v);
    return (v + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  task automatic pose_reset();
    for (int i = 0; i < 9; i++) pose_rot[i] = (i % 4 == 0) ? Q30_ONE : 0;
    for (int i = 0; i < 3; i++) pose_pos[i] = 0;
  endtask

  // Applies one joint to the kept pose and queues the pose on the last joint.
  task automatic apply_joint(input joint_t j);
    longint       d, a, st, ct, sa, ca, acc;
    longint       rj[9], pj[3], nr[9], np[3];
    logic [15:0]  th;
    logic [383:0] pose;
    d = longint'($signed(j.offset));
    a = longint'($signed(j.length));
    th = j.theta;
    if (j.kind == dhfk_pkg::KIND_PRISMATIC) d = sat32(d + longint'($signed(j.value)));
    else if (j.kind == dhfk_pkg::KIND_REVOLUTE) th = th + j.value[15:0];
    sin_cos(th, st, ct);
    sin_cos(j.twist, sa, ca);
    rj[0] = ct; rj[1] = -rnd30(st * ca); rj[2] = rnd30(st * sa);
    rj[3] = st; rj[4] = rnd30(ct * ca);  rj[5] = -rnd30(ct * sa);
    rj[6] = 0;  rj[7] = sa;              rj[8] = ca;
    pj[0] = sat32(rnd30(a * ct));
    pj[1] = sat32(rnd30(a * st));
    pj[2] = d;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += pose_rot[r * 3 + k] * rj[k * 3 + c];
        nr[r * 3 + c] = clip(rnd30(acc), -Q30_ONE, Q30_ONE);
      end
      acc = 0;
      for (int k = 0; k < 3; k++) acc += pose_rot[r * 3 + k] * pj[k];
      np[r] = sat32(rnd30(acc) + pose_pos[r]);
    end
    pose_rot = nr;
    pose_pos = np;
    if (j.last) begin
      for (int k = 0; k < 9; k++) pose[k * 32 +: 32] = pose_rot[k][31:0];
      for (int k = 0; k < 3; k++) pose[(9 + k) * 32 +: 32] = pose_pos[k][31:0];
      pose_q.insert(pose_q.size(), pose);
      pose_reset();
    end
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(30, 300);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
    endcase
  endfunction

  // Driver: presents queued joints, with random gaps between beats.
  always @(posedge clk_i) begin
    joint_t nx;
    logic   busy;
    busy = s_tvalid;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        apply_joint({s_tdata[31:0], s_tdata[47:32], s_tdata[79:48], s_tdata[95:80],
                     s_tuser, s_tdata[127:96], s_tlast});
        busy = 1'b0;
        tx_gap <= pick_gap();
      end
      if (!busy) begin
        if (tx_gap == 0 && joint_q.size() > 0) begin
          nx = joint_q.pop_front();
          s_tdata <= {nx.value, nx.twist, nx.length, nx.theta, nx.offset};
          s_tuser <= nx.kind;
          s_tlast <= nx.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
          if (tx_gap > 0 && !(s_tvalid && s_tready)) tx_gap <= tx_gap - 1;
        end
      end
    end
  end

  // Monitor: random backpressure, one long hold-off after reset.
  always @(posedge clk_i) begin
    logic [383:0] want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected pose beat %h", $time, m_tdata);
          errors++;
        end else begin
          want = pose_q.pop_front();
          for (int k = 0; k < 12; k++)
            if (want[k * 32 +: 32] !== m_tdata[k * 32 +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, k,
                       want[k * 32 +: 32], m_tdata[k * 32 +: 32]);
              errors++;
            end
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    joint_t j;
    pose_reset();
    // Single-joint chains first, so poses pile up behind the held receiver.
    j = '{offset: 32'h7FFF_FFFF, theta: 16'h0000, length: 32'h8000_0000,
          twist: 16'hFFFF, kind: dhfk_pkg::KIND_PRISMATIC, value: 32'h0001_0000,
          last: 1'b1};
    joint_q.insert(joint_q.size(), j);
    j = '{offset: 32'h8000_0000, theta: 16'hFFFF, length: 32'h7FFF_FFFF,
          twist: 16'h0000, kind: dhfk_pkg::KIND_PRISMATIC, value: 32'h8000_0000,
          last: 1'b1};
    joint_q.insert(joint_q.size(), j);
    j = '{offset: 32'h0000_0000, theta: 16'h4000, length: 32'h0001_0000,
          twist: 16'h2000, kind: dhfk_pkg::KIND_REVOLUTE, value: 32'hFFFF_E000,
          last: 1'b1};
    joint_q.insert(joint_q.size(), j);
    j = '{offset: 32'h0002_0000, theta: 16'h8000, length: 32'hFFFF_0000,
          twist: 16'hC000, kind: KIND_FIXED, value: 32'hFFFF_FFFF, last: 1'b1};
    joint_q.insert(joint_q.size(), j);
    j = '{offset: 32'h0003_0000, theta: 16'h6000, length: 32'h0000_8000,
          twist: 16'hA000, kind: KIND_UNUSED, value: 32'h1234_5678, last: 1'b1};
    joint_q.insert(joint_q.size(), j);
    // Octant edges and a chain that drives the position into saturation.
    for (int i = 0; i < 8; i++) begin
      j = '{offset: 32'h7000_0000, theta: 16'(i * 16'h2000 + (i % 2)),
            length: 32'h7FFF_FFFF, twist: 16'(i * 16'h2000 - 1),
            kind: dhfk_pkg::KIND_REVOLUTE, value: 32'hABCD_0000, last: i == 7};
      joint_q.insert(joint_q.size(), j);
    end
    for (int i = 0; i < 6; i++) begin
      j = '{offset: 32'h7FFF_FFFF, theta: 16'h0000, length: 32'h7FFF_FFFF,
            twist: 16'h0000, kind: dhfk_pkg::KIND_PRISMATIC, value: 32'h7FFF_FFFF,
            last: i == 5};
      joint_q.insert(joint_q.size(), j);
    end
    // Random chains of one to six joints.
    while (joint_q.size() < 520) begin
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        j.offset = pick_len();
        j.theta  = 16'($urandom);
        j.length = pick_len();
        j.twist  = 16'($urandom);
        j.kind   = $urandom_range(0, 9) == 0 ? KIND_UNUSED : 2'($urandom_range(0, 2));
        j.value  = j.kind == dhfk_pkg::KIND_PRISMATIC ? pick_len() : 32'($urandom);
        j.last   = i == n - 1;
        joint_q.insert(joint_q.size(), j);
      end
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Sampled at the falling edge, after the driver's updates have settled.
    do @(negedge clk_i); while (joint_q.size() > 0 || s_tvalid || pose_q.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
